// ===== rtl/core/cdl_pkg.sv =====
package cdl_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_LOAD     = 2'd1,
        OP_ARM_LEAP = 2'd2,
        OP_SPRING   = 2'd3
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [5:0] load_second;
        logic [5:0] load_minute;
        logic [4:0] load_hour;
        logic [4:0] load_day;
        logic [3:0] load_month;
        logic [6:0] load_year;
    } item_t;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic       summer;
    } cal_state_t;

    localparam int DATA_W = 40;

    localparam logic [6:0] SEC_LIMIT    = 7'd60;
    localparam logic [6:0] MIN_LIMIT    = 7'd60;
    localparam logic [5:0] HOUR_LIMIT   = 6'd24;
    localparam logic [4:0] MONTH_LIMIT  = 5'd13;
    localparam logic [7:0] YEAR_MAX     = 8'd99;
    localparam logic [5:0] LEAP_SECOND  = 6'd60;
    localparam logic [5:0] LAST_MINUTE  = 6'd59;
    localparam logic [3:0] SPRING_MONTH = 4'd3;
    localparam logic [3:0] AUTUMN_MONTH = 4'd10;
    localparam logic [5:0] DST_LOW_HOUR  = 6'd2;
    localparam logic [5:0] DST_HIGH_HOUR = 6'd3;
    localparam logic [4:0] LAST_DAY     = 5'd31;

    // Offset of the weekday sum for the 21st century (105 plus 5).
    localparam logic [8:0] WEEK_BASE = 9'd110;

    // Month term of the weekday sum, 13 * (m + 1) / 5, with January and
    // February (and month zero) counted as months 13, 14 and 12.
    function automatic logic [5:0] month_term(input logic [3:0] m);
        logic [5:0] term;
        case (m)
            4'd0, 4'd12: term = 6'd33;
            4'd1, 4'd13: term = 6'd36;
            4'd2, 4'd14: term = 6'd39;
            4'd3:        term = 6'd10;
            4'd4:        term = 6'd13;
            4'd5:        term = 6'd15;
            4'd6:        term = 6'd18;
            4'd7:        term = 6'd20;
            4'd8:        term = 6'd23;
            4'd9:        term = 6'd26;
            4'd10:       term = 6'd28;
            4'd11:       term = 6'd31;
            default:     term = 6'd41;
        endcase
        return term;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] len;
        case (m)
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = (y[1:0] != 2'd0) ? 5'd28 : 5'd29;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Remainder by seven: eight is one more than seven, so octal digits add up.
    function automatic logic [2:0] mod7(input logic [8:0] x);
        logic [4:0] s;
        logic [3:0] t;
        s = 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
        t = 4'(s[4:3]) + 4'(s[2:0]);
        if (t >= 4'd7)
        begin
            t = t - 4'd7;
        end
        return t[2:0];
    endfunction

    function automatic logic [2:0] weekday_calc(input logic [6:0] y, input logic [3:0] m,
                                                input logic [4:0] d);
        logic [6:0] ym;
        logic [8:0] base;
        logic [8:0] total;
        ym = y;
        if (m <= 4'd2)
        begin
            ym = y - 7'd1;
        end
        if (m <= 4'd2 && y == 7'd0)
        begin
            base = WEEK_BASE - 9'd2;
        end
        else
        begin
            base = WEEK_BASE + 9'(ym) + 9'(ym[6:2]);
        end
        total = base + 9'(d) + 9'(month_term(m));
        return mod7(total) + 3'd1;
    endfunction

    function automatic logic [4:0] last_sunday(input logic [6:0] y, input logic [3:0] m);
        logic [2:0] wd;
        logic [4:0] res;
        wd = weekday_calc(y, m, LAST_DAY);
        if (wd == 3'd7)
        begin
            res = LAST_DAY;
        end
        else
        begin
            res = LAST_DAY - 5'(wd);
        end
        return res;
    endfunction

    function automatic logic summer_calc(input logic [3:0] m, input logic [4:0] d,
                                         input logic [4:0] h, input logic [4:0] sd,
                                         input logic [4:0] ad);
        logic res;
        if ((m > SPRING_MONTH && m < AUTUMN_MONTH) || (m == SPRING_MONTH && d > sd)
            || (m == AUTUMN_MONTH && d < ad))
        begin
            res = 1'b1;
        end
        else if (m > AUTUMN_MONTH || m < SPRING_MONTH || (m == AUTUMN_MONTH && d > ad)
                 || (m == SPRING_MONTH && d < sd))
        begin
            res = 1'b0;
        end
        else if (m == SPRING_MONTH)
        begin
            res = (6'(h) >= DST_HIGH_HOUR);
        end
        else
        begin
            res = (6'(h) <= DST_LOW_HOUR);
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/cdl_state.sv =====
module cdl_state
    import cdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       utc_mode,
    input  logic       step_en,
    input  item_t      item,
    output cal_state_t cal
);

    logic [5:0] sec_reg, sec_next;
    logic [5:0] min_reg, min_next;
    logic [4:0] hour_reg, hour_next;
    logic [4:0] day_reg, day_next;
    logic [3:0] month_reg, month_next;
    logic [6:0] year_reg, year_next;
    logic       summer_reg, summer_next;
    logic       spring_reg, spring_next;
    logic       leap_reg, leap_next;
    logic [4:0] sd_reg, sd_next;
    logic [4:0] ad_reg, ad_next;

    logic [6:0] sec_inc;
    logic [6:0] min_inc;
    logic [5:0] hour_inc;
    logic [5:0] day_inc;
    logic [4:0] month_inc;
    logic [7:0] year_inc;
    logic [6:0] year_wrap;
    logic [6:0] rc_year;
    logic [4:0] sd_calc;
    logic [4:0] ad_calc;
    logic [5:0] hour_t;
    logic       summer_t;

    assign sec_inc   = 7'(sec_reg) + 7'd1;
    assign min_inc   = 7'(min_reg) + 7'd1;
    assign hour_inc  = 6'(hour_reg) + 6'd1;
    assign day_inc   = 6'(day_reg) + 6'd1;
    assign month_inc = 5'(month_reg) + 5'd1;
    assign year_inc  = 8'(year_reg) + 8'd1;
    assign year_wrap = (year_inc > YEAR_MAX) ? 7'd0 : year_inc[6:0];
    assign rc_year   = (item.op == OP_LOAD) ? item.load_year : year_wrap;
    assign sd_calc   = last_sunday(rc_year, SPRING_MONTH);
    assign ad_calc   = last_sunday(rc_year, AUTUMN_MONTH);

    always_comb
    begin
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        day_next    = day_reg;
        month_next  = month_reg;
        year_next   = year_reg;
        summer_next = summer_reg;
        spring_next = spring_reg;
        leap_next   = leap_reg;
        sd_next     = sd_reg;
        ad_next     = ad_reg;
        hour_t      = hour_inc;
        summer_t    = summer_reg;
        if (step_en)
        begin
            case (item.op)
                OP_TICK:
                begin
                    if (sec_inc < SEC_LIMIT)
                    begin
                        sec_next = sec_inc[5:0];
                    end
                    else if (leap_reg && min_reg == LAST_MINUTE && day_reg == 5'd1
                             && ((month_reg == 4'd7 && hour_reg == 5'd1)
                                 || (month_reg == 4'd1 && hour_reg == 5'd0)))
                    begin
                        sec_next  = LEAP_SECOND;
                        leap_next = 1'b0;
                    end
                    else
                    begin
                        sec_next = 6'd0;
                        if (min_inc < MIN_LIMIT)
                        begin
                            min_next = min_inc[5:0];
                        end
                        else
                        begin
                            min_next = 6'd0;
                            if (!utc_mode)
                            begin
                                if (spring_reg && hour_t == DST_LOW_HOUR && day_reg == sd_reg
                                    && month_reg == SPRING_MONTH)
                                begin
                                    hour_t      = DST_HIGH_HOUR;
                                    summer_t    = 1'b1;
                                    spring_next = 1'b0;
                                end
                                if (summer_t && hour_t == DST_HIGH_HOUR && day_reg == ad_reg
                                    && month_reg == AUTUMN_MONTH)
                                begin
                                    hour_t      = DST_LOW_HOUR;
                                    summer_t    = 1'b0;
                                    spring_next = 1'b0;
                                end
                            end
                            summer_next = summer_t;
                            if (hour_t < HOUR_LIMIT)
                            begin
                                hour_next = hour_t[4:0];
                            end
                            else
                            begin
                                hour_next = 5'd0;
                                if (day_inc <= 6'(month_len(month_reg, year_reg)))
                                begin
                                    day_next = day_inc[4:0];
                                end
                                else
                                begin
                                    day_next = 5'd1;
                                    if (month_inc < MONTH_LIMIT)
                                    begin
                                        month_next = month_inc[3:0];
                                    end
                                    else
                                    begin
                                        month_next = 4'd1;
                                        year_next  = year_wrap;
                                        if (year_wrap != 7'd0 && !utc_mode)
                                        begin
                                            sd_next     = sd_calc;
                                            ad_next     = ad_calc;
                                            summer_next = 1'b0;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                OP_LOAD:
                begin
                    sec_next   = item.load_second;
                    min_next   = item.load_minute;
                    hour_next  = item.load_hour;
                    day_next   = item.load_day;
                    month_next = item.load_month;
                    year_next  = item.load_year;
                    if (item.load_year != 7'd0 && !utc_mode)
                    begin
                        sd_next = sd_calc;
                        ad_next = ad_calc;
                        if (item.load_month != 4'd0 && item.load_day != 5'd0)
                        begin
                            summer_next = summer_calc(item.load_month, item.load_day,
                                                      item.load_hour, sd_calc, ad_calc);
                        end
                    end
                end
                OP_ARM_LEAP:
                begin
                    leap_next = 1'b1;
                end
                OP_SPRING:
                begin
                    spring_next = 1'b1;
                end
                default:
                begin
                    leap_next = leap_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg    <= '0;
            min_reg    <= '0;
            hour_reg   <= '0;
            day_reg    <= '0;
            month_reg  <= '0;
            year_reg   <= '0;
            summer_reg <= 1'b0;
            spring_reg <= 1'b0;
            leap_reg   <= 1'b0;
            sd_reg     <= '0;
            ad_reg     <= '0;
        end
        else
        begin
            sec_reg    <= sec_next;
            min_reg    <= min_next;
            hour_reg   <= hour_next;
            day_reg    <= day_next;
            month_reg  <= month_next;
            year_reg   <= year_next;
            summer_reg <= summer_next;
            spring_reg <= spring_next;
            leap_reg   <= leap_next;
            sd_reg     <= sd_next;
            ad_reg     <= ad_next;
        end
    end

    assign cal.second = sec_reg;
    assign cal.minute = min_reg;
    assign cal.hour   = hour_reg;
    assign cal.day    = day_reg;
    assign cal.month  = month_reg;
    assign cal.year   = year_reg;
    assign cal.summer = summer_reg;

`ifndef SYNTHESIS
    a_leap_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.op == OP_TICK && sec_next == LEAP_SECOND && sec_reg != LEAP_SECOND
        |=> !leap_reg)
        else $error("Leap second shown without clearing the pending flag.");

    a_spring_jump: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && item.op == OP_TICK && !utc_mode && hour_reg == 5'd1 && hour_next == 5'd3
        |=> summer_reg && !spring_reg)
        else $error("Spring hour skip without summer time in force.");

    a_flag_ops_keep_time: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (item.op == OP_ARM_LEAP || item.op == OP_SPRING)
        |=> $stable(sec_reg) && $stable(min_reg) && $stable(hour_reg) && $stable(day_reg))
        else $error("Flag operation changed the clock.");
`endif

endmodule

// ===== rtl/core/cdl_result.sv =====
module cdl_result
    import cdl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  cal_state_t        snap,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata
);

    logic              valid_reg, valid_next;
    logic [DATA_W-1:0] data_reg;
    logic [2:0]        weekday;

    assign weekday = (snap.month == 4'd0 || snap.day == 5'd0) ? 3'd0
                     : weekday_calc(snap.year, snap.month, snap.day);

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {3'd0, snap.summer, weekday, snap.year, snap.month, snap.day,
                         snap.hour, snap.minute, snap.second};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

`ifndef SYNTHESIS
    a_weekday_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> ((data_reg[25:22] == 4'd0 || data_reg[21:17] == 5'd0)
                       == (data_reg[35:33] == 3'd0)))
        else $error("Weekday does not match an unset date.");
`endif

endmodule

// ===== rtl/core/calendar_clock_dst_leap.sv =====
// Calendar clock, years 2000 to 2099, with leap second and summer time.
// The slave side takes one operation per transfer: tuser selects a one-second
// tick, a load of date and time from tdata, arming a leap second, or
// announcing the spring change. Every operation gives one result on the
// master side: the date and time after the operation, the weekday and the
// summer flag.
// A result is offered on the master side from the output register: the input
// register takes the transfer and feeds the update of the clock registers,
// which in turn load the output register. One operation is taken per cycle
// while the receiver keeps up, limited by the update of the clock registers.
// When the receiver stalls, the result waits in the output register, the
// next one waits in the clock stage, and the input register fills before
// s_tready drops; nothing is lost.
// Reset clears the clock, the date, all flags and utc_mode, and empties the
// pipeline. cfg_we writes utc_mode; write it only while the block is idle.
module calendar_clock_dst_leap
    import cdl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [DATA_W-1:0] s_tdata,  // load_second, load_minute, load_hour, load_day,
                                        // load_month, load_year, zero fill
    input  logic [1:0]        s_tuser,  // op
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata   // second, minute, hour, day, month, year,
                                        // weekday, summer, zero fill
);

    logic       utc_reg;
    logic       in_valid_reg, in_valid_next;
    item_t      item_reg;
    logic       step_valid_reg, step_valid_next;
    logic       out_free;
    logic       step_free;
    logic       step_en;
    logic       take;
    logic       move;
    cal_state_t cal;

    assign out_free  = !m_tvalid || m_tready;
    assign step_free = !step_valid_reg || out_free;
    assign step_en   = in_valid_reg && step_free;
    assign s_tready  = !in_valid_reg || step_en;
    assign take      = s_tvalid && s_tready;
    assign move      = step_valid_reg && out_free;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end
        step_valid_next = step_valid_reg;
        if (step_en)
        begin
            step_valid_next = 1'b1;
        end
        else if (move)
        begin
            step_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            utc_reg        <= 1'b0;
            in_valid_reg   <= 1'b0;
            step_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                utc_reg <= cfg_wdata;
            end
            in_valid_reg   <= in_valid_next;
            step_valid_reg <= step_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.op          <= op_t'(s_tuser);
            item_reg.load_second <= s_tdata[5:0];
            item_reg.load_minute <= s_tdata[11:6];
            item_reg.load_hour   <= s_tdata[16:12];
            item_reg.load_day    <= s_tdata[21:17];
            item_reg.load_month  <= s_tdata[25:22];
            item_reg.load_year   <= s_tdata[32:26];
        end
    end

    cdl_state u_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .utc_mode (utc_reg),
        .step_en  (step_en),
        .item     (item_reg),
        .cal      (cal)
    );

    cdl_result u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (move),
        .snap     (cal),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cdl_pkg::*;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        logic [2:0] weekday;
        logic       summer;
    } clock_reading_t;

    localparam int STALL_CYCLES = 60;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    logic              cfg_wdata = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [1:0]        s_tuser = OP_TICK;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;

    clock_reading_t expected_readings[$];
    int errors = 0;
    int readings_checked = 0;
    int items_sent = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int leap_seconds_shown = 0;
    int summer_changes = 0;
    int utc_writes = 0;
    int idle_pct = 31;
    bit stall_toggle = 1'b0;

    // Software copy of the clock.
    int cal_sec, cal_min, cal_hour, cal_day, cal_mon, cal_year;
    int spring_switch_day, autumn_switch_day;
    bit dst_on, spring_armed, leap_armed, utc_on;

    calendar_clock_dst_leap u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int days_in_month(input int m, input int y);
        if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            return 30;
        end
        if (m == 2)
        begin
            return (y % 4 != 0) ? 28 : 29;
        end
        return 31;
    endfunction

    // Zeller's congruence for the 21st century, 1 Monday to 7 Sunday.
    function automatic int zeller_weekday(input int y, input int m, input int d);
        int yy;
        int mm;
        int q;
        yy = y;
        mm = m;
        if (mm <= 2)
        begin
            mm += 12;
            yy -= 1;
        end
        q = (yy >= 0) ? yy / 4 : -1;
        return (d + 13 * (mm + 1) / 5 + yy + q + 105 + 5) % 7 + 1;
    endfunction

    function automatic int last_sunday_of(input int y, input int m);
        return 31 - (zeller_weekday(y, m, 31) % 7);
    endfunction

    function automatic void refresh_summer();
        if (cal_year == 0 || utc_on)
        begin
            return;
        end
        spring_switch_day = last_sunday_of(cal_year, SPRING_MONTH);
        autumn_switch_day = last_sunday_of(cal_year, AUTUMN_MONTH);
        if (cal_mon == 0 || cal_day == 0)
        begin
            return;
        end
        if ((cal_mon > SPRING_MONTH && cal_mon < AUTUMN_MONTH)
            || (cal_mon == SPRING_MONTH && cal_day > spring_switch_day)
            || (cal_mon == AUTUMN_MONTH && cal_day < autumn_switch_day))
        begin
            dst_on = 1'b1;
        end
        else if (cal_mon > AUTUMN_MONTH || cal_mon < SPRING_MONTH
                 || (cal_mon == AUTUMN_MONTH && cal_day > autumn_switch_day)
                 || (cal_mon == SPRING_MONTH && cal_day < spring_switch_day))
        begin
            dst_on = 1'b0;
        end
        else if (cal_mon == SPRING_MONTH)
        begin
            dst_on = (cal_hour >= 3);
        end
        else
        begin
            dst_on = (cal_hour <= 2);
        end
    endfunction

    function automatic void advance_day();
        cal_day++;
        if (cal_day <= days_in_month(cal_mon, cal_year))
        begin
            return;
        end
        cal_day = 1;
        cal_mon++;
        if (cal_mon < 13)
        begin
            return;
        end
        cal_mon = 1;
        cal_year++;
        if (cal_year > 99)
        begin
            cal_year = 0;
        end
        refresh_summer();
    endfunction

    function automatic void advance_hour();
        cal_hour++;
        if (!utc_on)
        begin
            if (spring_armed && cal_hour == 2 && cal_day == spring_switch_day
                && cal_mon == SPRING_MONTH)
            begin
                cal_hour = 3;
                dst_on = 1'b1;
                spring_armed = 1'b0;
                summer_changes++;
            end
            if (dst_on && cal_hour == 3 && cal_day == autumn_switch_day
                && cal_mon == AUTUMN_MONTH)
            begin
                cal_hour = 2;
                dst_on = 1'b0;
                spring_armed = 1'b0;
                summer_changes++;
            end
        end
        if (cal_hour < 24)
        begin
            return;
        end
        cal_hour = 0;
        advance_day();
    endfunction

    function automatic void advance_second();
        cal_sec++;
        if (cal_sec < 60)
        begin
            return;
        end
        if (leap_armed && cal_min == 59 && cal_day == 1
            && ((cal_mon == 7 && cal_hour == 1) || (cal_mon == 1 && cal_hour == 0)))
        begin
            cal_sec = 60;
            leap_armed = 1'b0;
            leap_seconds_shown++;
            return;
        end
        cal_sec = 0;
        cal_min++;
        if (cal_min < 60)
        begin
            return;
        end
        cal_min = 0;
        advance_hour();
    endfunction

    function automatic clock_reading_t step_clock(input item_t it);
        clock_reading_t r;
        case (it.op)
            OP_TICK:
            begin
                advance_second();
            end
            OP_LOAD:
            begin
                cal_sec  = it.load_second;
                cal_min  = it.load_minute;
                cal_hour = it.load_hour;
                cal_day  = it.load_day;
                cal_mon  = it.load_month;
                cal_year = it.load_year;
                refresh_summer();
            end
            OP_ARM_LEAP:
            begin
                leap_armed = 1'b1;
            end
            OP_SPRING:
            begin
                spring_armed = 1'b1;
            end
        endcase
        r.second  = 6'(cal_sec);
        r.minute  = 6'(cal_min);
        r.hour    = 5'(cal_hour);
        r.day     = 5'(cal_day);
        r.month   = 4'(cal_mon);
        r.year    = 7'(cal_year);
        r.weekday = (cal_mon == 0 || cal_day == 0) ? 3'd0
                    : 3'(zeller_weekday(cal_year, cal_mon, cal_day));
        r.summer  = dst_on;
        return r;
    endfunction

    function automatic item_t load_item(input int s, input int mi, input int h, input int d,
                                        input int mo, input int y);
        item_t it;
        it.op          = OP_LOAD;
        it.load_second = 6'(s);
        it.load_minute = 6'(mi);
        it.load_hour   = 5'(h);
        it.load_day    = 5'(d);
        it.load_month  = 4'(mo);
        it.load_year   = 7'(y);
        return it;
    endfunction

    // The load fields carry random content; only a load may look at them.
    function automatic item_t noise_item(input op_t op);
        logic [63:0] bits;
        item_t it;
        bits = {$urandom(), $urandom()};
        it = bits[$bits(item_t)-1:0];
        it.op = op;
        return it;
    endfunction

    task automatic send_item(input item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tdata  <= DATA_W'({it.load_year, it.load_month, it.load_day, it.load_hour,
                             it.load_minute, it.load_second});
        do
            @(posedge clk);
        while (!s_tready);
        expected_readings.push_back(step_clock(it));
        op_count[it.op]++;
        items_sent++;
    endtask

    task automatic send_op(input op_t op);
        send_item(noise_item(op));
    endtask

    task automatic send_load(input int s, input int mi, input int h, input int d,
                             input int mo, input int y);
        send_item(load_item(s, mi, h, d, mo, y));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_utc_mode(input bit v);
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        utc_on = v;
        utc_writes++;
    endtask

    task automatic test_reset_and_extremes();
        send_op(OP_TICK);
        send_load(63, 63, 31, 31, 15, 127);
        send_op(OP_TICK);
        send_load(59, 59, 23, 31, 12, 99);
        send_op(OP_TICK);
        send_load(0, 0, 0, 1, 1, 0);
        send_load(0, 0, 0, 0, 0, 0);
        send_load(59, 59, 23, 28, 2, 24);
        send_op(OP_TICK);
        send_load(59, 59, 23, 28, 2, 23);
        send_op(OP_TICK);
        send_load(59, 59, 23, 30, 4, 10);
        send_op(OP_TICK);
    endtask

    task automatic test_leap_second();
        send_op(OP_ARM_LEAP);
        send_load(59, 59, 1, 1, 7, 15);
        send_op(OP_TICK);
        send_op(OP_TICK);
        send_load(59, 59, 0, 1, 1, 16);
        send_op(OP_TICK);
        send_op(OP_ARM_LEAP);
        send_load(59, 59, 0, 1, 1, 16);
        send_op(OP_TICK);
        send_op(OP_TICK);
    endtask

    task automatic test_summer_time();
        int sd;
        int ad;
        sd = last_sunday_of(24, SPRING_MONTH);
        ad = last_sunday_of(24, AUTUMN_MONTH);
        send_load(59, 59, 1, sd, 3, 24);
        send_op(OP_TICK);
        send_op(OP_SPRING);
        send_load(59, 59, 1, sd, 3, 24);
        send_op(OP_TICK);
        send_load(59, 59, 2, ad, 10, 24);
        send_op(OP_TICK);
        send_load(59, 59, 23, 31, 12, 24);
        send_op(OP_TICK);
        send_load(0, 0, 12, 15, 6, 0);
    endtask

    task automatic test_utc_mode();
        int sd;
        sd = last_sunday_of(24, SPRING_MONTH);
        settle();
        write_utc_mode(1'b1);
        send_op(OP_SPRING);
        send_load(59, 59, 1, sd, 3, 24);
        send_op(OP_TICK);
        send_load(59, 59, 23, 31, 12, 30);
        send_op(OP_TICK);
        settle();
        write_utc_mode(1'b0);
    endtask

    // The sender keeps offering while the receiver holds off, so the pipeline fills.
    task automatic test_output_stall();
        idle_pct = 0;
        send_load(50, 59, 23, 31, 12, 47);
        stall_toggle = ~stall_toggle;
        repeat (40) send_op(OP_TICK);
        settle();
        idle_pct = 31;
    endtask

    task automatic random_sequence();
        int y;
        int mo;
        int d;
        int h;
        int mi;
        int s;
        case ($urandom_range(19))
            0, 1:    y = 0;
            2:       y = $urandom_range(100, 127);
            default: y = $urandom_range(1, 99);
        endcase
        s = $urandom_range(50, 59);
        case ($urandom_range(5))
            0:
            begin
                mo = 7;
                d  = 1;
                h  = 1;
                s  = $urandom_range(56, 59);
            end
            1:
            begin
                mo = 1;
                d  = 1;
                h  = 0;
                s  = $urandom_range(56, 59);
            end
            2:
            begin
                mo = SPRING_MONTH;
                d  = last_sunday_of(y, SPRING_MONTH);
                h  = $urandom_range(1, 2);
            end
            3:
            begin
                mo = AUTUMN_MONTH;
                d  = last_sunday_of(y, AUTUMN_MONTH);
                h  = $urandom_range(1, 3);
            end
            4:
            begin
                mo = $urandom_range(1, 12);
                d  = days_in_month(mo, y);
                h  = 23;
            end
            default:
            begin
                mo = $urandom_range(1, 12);
                d  = $urandom_range(1, days_in_month(mo, y));
                h  = $urandom_range(0, 23);
                s  = $urandom_range(0, 59);
            end
        endcase
        mi = ($urandom_range(3) != 0) ? 59 : $urandom_range(0, 59);
        if ($urandom_range(3) == 0)
        begin
            send_op(OP_ARM_LEAP);
        end
        if ($urandom_range(2) == 0)
        begin
            send_op(OP_SPRING);
        end
        send_load(s, mi, h, d, mo, y);
        repeat ($urandom_range(1, 8)) send_op(OP_TICK);
    endtask

    task automatic run_random(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n)
        begin
            if ($urandom_range(4) != 0)
            begin
                random_sequence();
            end
            else
            begin
                send_item(noise_item(op_t'($urandom_range(3))));
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random(200);
        settle();
        write_utc_mode(1'b1);
        run_random(120);
        settle();
        write_utc_mode(1'b0);
        idle_pct = 0;
        run_random(150);
        idle_pct = 31;
        run_random(150);
    endtask

    initial
    begin : receiver
        int stall_left;
        bit stall_seen;
        logic ready_next;
        stall_left = 0;
        stall_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_toggle != stall_seen)
            begin
                stall_seen = stall_toggle;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0)
            begin
                ready_next = 1'b0;
                stall_left--;
            end
            else
            begin
                ready_next = ($urandom_range(99) >= idle_pct);
            end
            @(posedge clk);
            m_tready <= ready_next;
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_checker
        clock_reading_t got;
        clock_reading_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = {m_tdata[5:0], m_tdata[11:6], m_tdata[16:12], m_tdata[21:17],
                   m_tdata[25:22], m_tdata[32:26], m_tdata[35:33], m_tdata[36]};
            if (expected_readings.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, m_tdata);
            end
            else
            begin
                want = expected_readings.pop_front();
                check_field("second", want.second, got.second);
                check_field("minute", want.minute, got.minute);
                check_field("hour", want.hour, got.hour);
                check_field("day", want.day, got.day);
                check_field("month", want.month, got.month);
                check_field("year", want.year, got.year);
                check_field("weekday", want.weekday, got.weekday);
                check_field("summer", want.summer, got.summer);
                readings_checked++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results outstanding.", expected_readings.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        cal_sec = 0;
        cal_min = 0;
        cal_hour = 0;
        cal_day = 0;
        cal_mon = 0;
        cal_year = 0;
        spring_switch_day = 0;
        autumn_switch_day = 0;
        dst_on = 1'b0;
        spring_armed = 1'b0;
        leap_armed = 1'b0;
        utc_on = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_and_extremes();
        test_leap_second();
        test_summer_time();
        test_utc_mode();
        test_output_stall();
        test_random_traffic();
        settle();
        repeat (10) @(posedge clk);
        if (expected_readings.size() != 0)
        begin
            errors++;
            $display("%0t ns: %0d expected results never arrived", $time,
                     expected_readings.size());
        end
        $display("Ran %0d ticks, %0d loads, %0d leap arms and %0d spring announcements;",
                 op_count[OP_TICK], op_count[OP_LOAD], op_count[OP_ARM_LEAP],
                 op_count[OP_SPRING]);
        $display("%0d results checked, %0d leap seconds, %0d summer changes, %0d mode writes.",
                 readings_checked, leap_seconds_shown, summer_changes, utc_writes);
        if (errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
